/* src/dema_pkg.sv */
// Shared constants and control types of the dual EMA crossover indicator.
package dema_pkg;

    localparam int MAX_PERIOD_DEF = 64;

    localparam int PRICE_W   = 40;
    localparam int AVG_W     = 48;
    localparam int PER_W     = 7;
    localparam int K_W       = 24;
    localparam int CFG_IDX_W = 1;
    localparam int DVD_W     = AVG_W + 1;

    localparam logic [PER_W-1:0] FAST_PERIOD_RST = 7'd12;
    localparam logic [PER_W-1:0] SLOW_PERIOD_RST = 7'd26;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD = 1'b1;

    localparam logic SEL_FAST = 1'b0;
    localparam logic SEL_SLOW = 1'b1;

    typedef struct packed {
        logic load;
        logic sel;
        logic acc;
        logic seed_start;
        logic k_start;
        logic mul;
        logic upd;
        logic wr_seed;
        logic wr_k;
        logic res;
    } dema_cmd_t;

    typedef struct packed {
        logic seeded;
        logic k_stale;
        logic seed_due;
        logic div_done;
    } dema_sts_t;

endpackage

/* src/dema_div.sv */
// Restoring divider, one quotient bit per cycle.
module dema_div #(
    parameter int DVD_W = dema_pkg::DVD_W,
    parameter int DVS_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CW = $clog2(DVD_W);

    logic             run_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   rem_sub;

    assign trial   = {rem_reg, quo_reg[DVD_W-1]};
    assign ge      = trial >= {1'b0, dvs_reg};
    assign rem_sub = ge ? (trial - {1'b0, dvs_reg}) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DVD_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= rem_sub[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("divider done without a running division");

endmodule

/* src/dema_datapath.sv */
// Datapath: configuration, averages, coefficients, shared divider and multiplier, result.
module dema_datapath #(
    parameter int MAX_PERIOD = dema_pkg::MAX_PERIOD_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dema_pkg::dema_cmd_t               cmd,
    output dema_pkg::dema_sts_t               sts,
    input  logic                              cfg_we,
    input  logic [dema_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dema_pkg::PER_W-1:0]        cfg_data,
    input  logic [dema_pkg::PRICE_W-1:0]      close_price,
    input  logic                              first_of_series,
    output logic                              valid_res,
    output logic                              bull,
    output logic [dema_pkg::PRICE_W-1:0]      spread
);

    localparam int PRICE_W = dema_pkg::PRICE_W;
    localparam int AVG_W   = dema_pkg::AVG_W;
    localparam int PER_W   = dema_pkg::PER_W;
    localparam int K_W     = dema_pkg::K_W;
    localparam int DVD_W   = dema_pkg::DVD_W;
    localparam int CNT_W   = $clog2(MAX_PERIOD + 1);
    localparam int DVS_W   = CNT_W + 1;
    localparam int PW      = (CNT_W > PER_W) ? CNT_W : PER_W;
    localparam int PROD_W  = PRICE_W + 1 + K_W + 1;

    function automatic logic [CNT_W-1:0] clamp_period(input logic [PER_W-1:0] p);
        logic [PW-1:0] pe;
        logic [PW-1:0] r;
        pe = PW'(p);
        if (pe < PW'(2))
            r = PW'(2);
        else if (pe > PW'(MAX_PERIOD))
            r = PW'(MAX_PERIOD);
        else
            r = pe;
        return r[CNT_W-1:0];
    endfunction

    logic [PER_W-1:0]   fast_period_reg;
    logic [PER_W-1:0]   slow_period_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [AVG_W-1:0]   avg_reg     [2];
    logic               seeded_reg  [2];
    logic [K_W-1:0]     k_reg       [2];
    logic               k_stale_reg [2];
    logic [PRICE_W-1:0] price_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               valid_res_reg;
    logic               bull_reg;
    logic [PRICE_W-1:0] spread_reg;

    logic [CNT_W-1:0]   p_sel;
    logic [DVS_W-1:0]   p_inc;
    logic [AVG_W-1:0]   avg_sel;
    logic [K_W-1:0]     k_sel;
    logic [AVG_W-1:0]   sum_sel;
    logic [DVD_W-1:0]   seed_dvd;
    logic [DVD_W-1:0]   k_dvd;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_quo;
    logic [CNT_W-1:0]   cnt_base;
    logic [CNT_W-1:0]   count_next;
    logic [PRICE_W-1:0] a_sel;
    logic signed [PRICE_W:0]  delta;
    logic signed [K_W:0]      k_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] step;
    logic [AVG_W-1:0]   upd_avg;
    logic               gt;
    logic [AVG_W-1:0]   diff;
    logic [PRICE_W-1:0] diff_sat;

    assign p_sel   = cmd.sel ? clamp_period(slow_period_reg) : clamp_period(fast_period_reg);
    assign p_inc   = DVS_W'(p_sel) + DVS_W'(1);
    assign avg_sel = avg_reg[cmd.sel];
    assign k_sel   = k_reg[cmd.sel];
    assign sum_sel = avg_sel + AVG_W'(price_reg);

    assign seed_dvd = DVD_W'(sum_sel) + DVD_W'(count_reg >> 1);
    assign k_dvd    = (DVD_W'(1) << (K_W + 1)) + DVD_W'(p_inc >> 1);
    assign div_dvd  = cmd.k_start ? k_dvd : seed_dvd;
    assign div_dvs  = cmd.k_start ? p_inc : DVS_W'(count_reg);

    dema_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.seed_start | cmd.k_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cnt_base   = first_of_series ? '0 : count_reg;
    assign count_next = (cnt_base < CNT_W'(MAX_PERIOD)) ? (cnt_base + CNT_W'(1)) : cnt_base;

    assign a_sel     = avg_sel[PRICE_W-1:0];
    assign delta     = $signed({1'b0, price_reg}) - $signed({1'b0, a_sel});
    assign k_s       = $signed({1'b0, k_sel});
    assign prod_next = delta * k_s;
    assign rnd       = prod_reg + $signed(PROD_W'(1) << (K_W - 1));
    assign step      = rnd >>> K_W;
    assign upd_avg   = AVG_W'(a_sel) + step[AVG_W-1:0];

    assign gt       = avg_reg[0] > avg_reg[1];
    assign diff     = gt ? (avg_reg[0] - avg_reg[1]) : (avg_reg[1] - avg_reg[0]);
    assign diff_sat = (|diff[AVG_W-1:PRICE_W]) ? '1 : diff[PRICE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_period_reg <= dema_pkg::FAST_PERIOD_RST;
            slow_period_reg <= dema_pkg::SLOW_PERIOD_RST;
            count_reg       <= '0;
            avg_reg[0]      <= '0;
            avg_reg[1]      <= '0;
            seeded_reg[0]   <= 1'b0;
            seeded_reg[1]   <= 1'b0;
            k_stale_reg[0]  <= 1'b1;
            k_stale_reg[1]  <= 1'b1;
        end
        else
        begin
            if (cfg_we && cfg_index == dema_pkg::REG_FAST_PERIOD)
            begin
                fast_period_reg <= cfg_data;
                k_stale_reg[0]  <= 1'b1;
            end
            if (cfg_we && cfg_index == dema_pkg::REG_SLOW_PERIOD)
            begin
                slow_period_reg <= cfg_data;
                k_stale_reg[1]  <= 1'b1;
            end
            if (cmd.load)
            begin
                count_reg <= count_next;
                if (first_of_series)
                begin
                    avg_reg[0]    <= '0;
                    avg_reg[1]    <= '0;
                    seeded_reg[0] <= 1'b0;
                    seeded_reg[1] <= 1'b0;
                end
            end
            if (cmd.acc)
                avg_reg[cmd.sel] <= sum_sel;
            if (cmd.upd)
                avg_reg[cmd.sel] <= upd_avg;
            if (cmd.wr_seed)
            begin
                avg_reg[cmd.sel]    <= div_quo[AVG_W-1:0];
                seeded_reg[cmd.sel] <= 1'b1;
            end
            if (cmd.wr_k)
                k_stale_reg[cmd.sel] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            price_reg <= close_price;
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.wr_k)
            k_reg[cmd.sel] <= div_quo[K_W-1:0];
        if (cmd.res)
        begin
            valid_res_reg <= seeded_reg[0] & seeded_reg[1];
            bull_reg      <= seeded_reg[0] & seeded_reg[1] & gt;
            spread_reg    <= (seeded_reg[0] & seeded_reg[1]) ? diff_sat : '0;
        end
    end

    assign sts.seeded   = seeded_reg[cmd.sel];
    assign sts.k_stale  = k_stale_reg[cmd.sel];
    assign sts.seed_due = count_reg >= p_sel;
    assign sts.div_done = div_done;

    assign valid_res = valid_res_reg;
    assign bull      = bull_reg;
    assign spread    = spread_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PERIOD))
        else $error("sample count beyond maximum period");

    a_seed_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_seed |=> seeded_reg[$past(cmd.sel)])
        else $error("seed written but average not marked seeded");

endmodule

/* src/dema_ctrl.sv */
// Controller: sequences load, per-average warmup/seed/update and result transfer.
module dema_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output dema_pkg::dema_cmd_t cmd,
    input  dema_pkg::dema_sts_t sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_K    = 1'b1;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       sel_reg;
    logic       sel_next;
    logic       kind_reg;
    logic       kind_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.sel        = sel_reg;
        state_next     = state_reg;
        sel_next       = sel_reg;
        kind_next      = kind_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = dema_pkg::SEL_FAST;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!sts.seeded)
                begin
                    if (sts.seed_due)
                    begin
                        cmd.seed_start = 1'b1;
                        kind_next      = KIND_SEED;
                        state_next     = S_DIV;
                    end
                    else
                    begin
                        cmd.acc = 1'b1;
                        if (sel_reg == dema_pkg::SEL_FAST)
                            sel_next = dema_pkg::SEL_SLOW;
                        else
                            state_next = S_OUT;
                    end
                end
                else if (sts.k_stale)
                begin
                    cmd.k_start = 1'b1;
                    kind_next   = KIND_K;
                    state_next  = S_DIV;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    if (kind_reg == KIND_SEED)
                    begin
                        cmd.wr_seed = 1'b1;
                        if (sel_reg == dema_pkg::SEL_FAST)
                        begin
                            sel_next   = dema_pkg::SEL_SLOW;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        cmd.wr_k   = 1'b1;
                        state_next = S_EVAL;
                    end
                end
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (sel_reg == dema_pkg::SEL_FAST)
                begin
                    sel_next   = dema_pkg::SEL_SLOW;
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.res        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= dema_pkg::SEL_FAST;
            kind_reg      <= KIND_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_res_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transfer");

    a_res_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res |=> out_valid_reg)
        else $error("result loaded without output valid");

endmodule

/* src/dual_ema_crossover_indicator_unit.sv */
// Top level of the dual EMA crossover indicator.
// Takes one closing price per transfer and returns one result per price: valid_res once
// both the fast and the slow average are seeded, the bull sign and the saturated spread.
// Once both averages are seeded an item goes through load, then evaluate and update for
// each average through one shared 41x25 multiplier, then result. While both still warm
// up it goes through load, an accumulate for each average, then result. The seeding
// sample of an average adds a run of the shared restoring divider (one quotient bit per
// cycle). The first update after reset, or after its period register is written, adds
// for that average the divider run that forms the coefficient plus a second evaluate.
// The result sits in an output register, so the next price can be taken while it waits
// for its transfer. The user must write period registers only while idle; the block
// itself does not enforce it.
module dual_ema_crossover_indicator_unit #(
    parameter int MAX_PERIOD = dema_pkg::MAX_PERIOD_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dema_pkg::PRICE_W-1:0]      close_price,
    input  logic                              first_of_series,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              valid_res,
    output logic                              bull,
    output logic [dema_pkg::PRICE_W-1:0]      spread,
    input  logic                              cfg_we,
    input  logic [dema_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dema_pkg::PER_W-1:0]        cfg_data
);

    dema_pkg::dema_cmd_t cmd;
    dema_pkg::dema_sts_t sts;

    dema_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dema_datapath #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .close_price     (close_price),
        .first_of_series (first_of_series),
        .valid_res       (valid_res),
        .bull            (bull),
        .spread          (spread)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the dual EMA crossover indicator: directed table plus random series.
`timescale 1ns / 1ps

module tb;

    localparam int PRICE_W   = dema_pkg::PRICE_W;
    localparam int AVG_W     = dema_pkg::AVG_W;
    localparam int PER_W     = dema_pkg::PER_W;
    localparam int CFG_IDX_W = dema_pkg::CFG_IDX_W;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD = dema_pkg::REG_FAST_PERIOD;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD = dema_pkg::REG_SLOW_PERIOD;

    localparam int MAX_PER = dema_pkg::MAX_PERIOD_DEF;
    localparam int DIR_ROWS = 24;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 200;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [PRICE_W-1:0] PMAX = '1;

    typedef struct packed {
        logic               valid_res;
        logic               bull;
        logic [PRICE_W-1:0] spread;
    } xover_t;

    typedef enum logic {ROW_XFER, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [PRICE_W-1:0]     price;
        logic                   first;
        logic                   checked;
        xover_t                 want;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [PER_W-1:0]       reg_val;
    } stim_row_t;

    localparam xover_t NONE = '{1'b0, 1'b0, 40'd0};
    localparam xover_t SEEDED_EQ = '{1'b1, 1'b0, 40'd0};

    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_XFER, 40'd0,          1'b1, 1'b1, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, PMAX,           1'b0, 1'b1, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_CFG,  40'd0,          1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_CFG,  40'd0,          1'b0, 1'b0, NONE,      REG_SLOW_PERIOD, 7'd1},
        '{ROW_XFER, PMAX,           1'b1, 1'b1, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, 40'd0,          1'b0, 1'b1, SEEDED_EQ, REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, PMAX,           1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_CFG,  40'd0,          1'b0, 1'b0, NONE,      REG_SLOW_PERIOD, 7'd3},
        '{ROW_XFER, PMAX,           1'b1, 1'b1, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, PMAX,           1'b0, 1'b1, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, 40'd0,          1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, 40'd0,          1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, PMAX,           1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_CFG,  40'd0,          1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd127},
        '{ROW_CFG,  40'd0,          1'b0, 1'b0, NONE,      REG_SLOW_PERIOD, 7'd64},
        '{ROW_XFER, 40'h123456789A, 1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, 40'd0,          1'b1, 1'b1, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_CFG,  40'd0,          1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd2},
        '{ROW_XFER, PMAX,           1'b0, 1'b1, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, 40'd1,          1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_CFG,  40'd0,          1'b0, 1'b0, NONE,      REG_SLOW_PERIOD, 7'd2},
        '{ROW_XFER, 40'd5,          1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, 40'hAAAAAAAAAA, 1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0},
        '{ROW_XFER, 40'h5555555555, 1'b0, 1'b0, NONE,      REG_FAST_PERIOD, 7'd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [PRICE_W-1:0]     close_price;
    logic                   first_of_series;
    logic                   out_valid;
    logic                   out_ready;
    logic                   valid_res;
    logic                   bull;
    logic [PRICE_W-1:0]     spread;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [PER_W-1:0]       cfg_data;

    logic [PER_W-1:0]       fast_period_q = dema_pkg::FAST_PERIOD_RST;
    logic [PER_W-1:0]       slow_period_q = dema_pkg::SLOW_PERIOD_RST;
    int                     series_count = 0;
    logic [AVG_W-1:0]       fast_ema = '0;
    logic [AVG_W-1:0]       slow_ema = '0;
    logic                   fast_seeded = 1'b0;
    logic                   slow_seeded = 1'b0;

    xover_t                 crossover_q [$];
    int                     mismatch_count = 0;
    bit                     idle_on = 1'b1;
    int                     hold_req = 0;

    dual_ema_crossover_indicator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .close_price     (close_price),
        .first_of_series (first_of_series),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .valid_res       (valid_res),
        .bull            (bull),
        .spread          (spread),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int eff_period(input logic [PER_W-1:0] preg);
        if (preg < 2) return 2;
        if (preg > MAX_PER) return MAX_PER;
        return int'(preg);
    endfunction

    function automatic logic [AVG_W:0] ema_next(input logic [AVG_W-1:0] ema,
                                                input logic seeded,
                                                input logic [PER_W-1:0] preg,
                                                input logic [PRICE_W-1:0] price,
                                                input int count);
        int               p;
        logic [65:0]      k;
        logic [65:0]      acc;
        logic [AVG_W-1:0] sum;
        p = eff_period(preg);
        if (!seeded)
        begin
            sum = ema + price;
            if (count < p) return {1'b0, sum};
            sum = (sum + 48'(count / 2)) / 48'(count);
            return {1'b1, sum};
        end
        k = ((66'd1 << 25) + 66'((p + 1) / 2)) / 66'(p + 1);
        acc = (price * k + ema[PRICE_W-1:0] * ((66'd1 << 24) - k) + (66'd1 << 23)) >> 24;
        return {1'b1, acc[AVG_W-1:0]};
    endfunction

    function automatic xover_t crossover_predict(input logic [PRICE_W-1:0] price,
                                                 input logic first);
        xover_t           r;
        logic [AVG_W-1:0] d;
        if (first)
        begin
            series_count = 0;
            fast_ema = '0;
            slow_ema = '0;
            fast_seeded = 1'b0;
            slow_seeded = 1'b0;
        end
        if (series_count < MAX_PER) series_count++;
        {fast_seeded, fast_ema} = ema_next(fast_ema, fast_seeded, fast_period_q, price,
                                           series_count);
        {slow_seeded, slow_ema} = ema_next(slow_ema, slow_seeded, slow_period_q, price,
                                           series_count);
        r = '0;
        if (fast_seeded && slow_seeded)
        begin
            r.valid_res = 1'b1;
            r.bull = fast_ema > slow_ema;
            d = r.bull ? fast_ema - slow_ema : slow_ema - fast_ema;
            r.spread = (d > 48'(PMAX)) ? PMAX : d[PRICE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [PER_W-1:0] draw_period();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 7'd127;
        if (sel == 1) return PER_W'($urandom_range(0, 1));
        if (sel == 2) return PER_W'($urandom_range(40, 70));
        return PER_W'($urandom_range(2, 24));
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic push_price(input logic [PRICE_W-1:0] price, input logic first,
                              input logic checked, input xover_t want);
        xover_t got;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        close_price <= price;
        first_of_series <= first;
        do @(posedge clk); while (!in_ready);
        got = crossover_predict(price, first);
        crossover_q.push_back(checked ? want : got);
    endtask

    task automatic write_period(input logic [CFG_IDX_W-1:0] idx, input logic [PER_W-1:0] val);
        @(negedge clk) in_valid <= 1'b0;
        wait (crossover_q.size() == 0);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk) cfg_we <= 1'b0;
        if (idx == REG_FAST_PERIOD) fast_period_q = val;
        else slow_period_q = val;
    endtask

    initial
    begin : drain_side
        int hold_len;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_len = hold_req;
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_out
        xover_t want;
        if (out_valid && out_ready)
        begin
            if (crossover_q.size() == 0)
            begin
                note_mismatch("result transfer with no price pending");
            end
            else
            begin
                want = crossover_q.pop_front();
                if (valid_res !== want.valid_res)
                    note_mismatch($sformatf("valid_res got %b want %b",
                                            valid_res, want.valid_res));
                if (bull !== want.bull)
                    note_mismatch($sformatf("bull got %b want %b", bull, want.bull));
                if (spread !== want.spread)
                    note_mismatch($sformatf("spread got %h want %h", spread, want.spread));
            end
        end
    end

    initial
    begin : stimulus
        int                 i;
        int                 ph;
        int                 n;
        int                 series_left;
        int                 span;
        logic [PER_W-1:0]   fp;
        logic [PER_W-1:0]   sp;
        logic               first;
        logic [PRICE_W-1:0] price_now;
        logic [63:0]        wide;
        logic [63:0]        step;

        rst_n = 1'b0;
        in_valid = 1'b0;
        close_price = '0;
        first_of_series = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        series_left = 0;
        price_now = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
                write_period(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_val);
            else
                push_price(DIR_TAB[i].price, DIR_TAB[i].first, DIR_TAB[i].checked,
                           DIR_TAB[i].want);
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = (ph != 3) && (ph < RAND_PHASES - 2);
            case (ph)
                0:
                begin
                    fp = 7'd2;
                    sp = 7'd64;
                end
                1:
                begin
                    fp = 7'd64;
                    sp = 7'd2;
                end
                2:
                begin
                    fp = 7'd0;
                    sp = 7'd127;
                end
                default:
                begin
                    fp = draw_period();
                    sp = draw_period();
                end
            endcase
            write_period(REG_FAST_PERIOD, fp);
            write_period(REG_SLOW_PERIOD, sp);
            if (ph == 5) hold_req = 300;
            span = (eff_period(fp) > eff_period(sp) ? eff_period(fp) : eff_period(sp)) + 40;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (series_left == 0)
                begin
                    series_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                               : $urandom_range(1, span);
                    wide = {$urandom, $urandom};
                    price_now = wide[PRICE_W-1:0];
                    first = 1'b1;
                end
                else
                begin
                    first = ($urandom_range(0, 49) == 0);
                    if ($urandom_range(0, 15) == 0)
                    begin
                        wide = {$urandom, $urandom};
                        case ($urandom_range(0, 2))
                            0: price_now = '0;
                            1: price_now = PMAX;
                            default: price_now = wide[PRICE_W-1:0];
                        endcase
                    end
                    else
                    begin
                        wide = {$urandom, $urandom};
                        step = wide & ((64'd1 << $urandom_range(0, 36)) - 64'd1);
                        if ($urandom_range(0, 1) == 1)
                            price_now = (64'(price_now) + step > 64'(PMAX))
                                        ? PMAX : price_now + step[PRICE_W-1:0];
                        else
                            price_now = (step > 64'(price_now))
                                        ? '0 : price_now - step[PRICE_W-1:0];
                    end
                end
                series_left--;
                push_price(price_now, first, 1'b0, NONE);
            end
        end

        @(negedge clk) in_valid <= 1'b0;
        wait (crossover_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* dual_ema_crossover_indicator_unit.f */
src/dema_pkg.sv
src/dema_div.sv
src/dema_datapath.sv
src/dema_ctrl.sv
src/dual_ema_crossover_indicator_unit.sv
verif/tb.sv
